[sv/qpe_pkg.sv]
// package for the query parameter extractor
// holds codes, state and result types, and hex helper functions; no dependencies
package qpe_pkg;

    localparam int MAX_NAME_BYTES = 8;
    localparam int NAME_W         = 64;
    localparam int NAME_LEN_W     = 4;
    localparam int KEY_POS_W      = 4;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACE_FOR_PLUS = 2'd2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_QMARK   = 8'h3f;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [4:0] {
        PH_BEFORE = 5'b00001,
        PH_KEY    = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [1:0]             escape_stage;
        logic [3:0]             high_nibble;
        logic [KEY_POS_W-1:0]   key_position;
        logic                   key_mismatch;
    } scan_state_t;

    typedef struct packed {
        logic [NAME_W-1:0]      name_bytes;
        logic [NAME_LEN_W-1:0]  name_length;
        logic                   space_for_plus;
    } qpe_cfg_t;

    typedef struct packed {
        logic                   present;
        logic [7:0]             value_byte;
        logic                   byte_valid;
        logic [1:0]             status;
        logic                   finished;
    } qpe_result_t;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

[sv/query_parameter_extract_core.sv]
// Takes one byte of the request target per cycle, at full rate: an accepted byte updates the
// scan state in the same cycle and its result, if any, lands in the output register, which
// is taken again in the cycle it drains, so a byte can be accepted every clock while
// m_tready stays high. The rate is set by the combinational next-state logic in qpe_step.
// depends on qpe_pkg and qpe_step
module query_parameter_extract_core import qpe_pkg::*; #(
    parameter int NAME_BYTES_MAX = MAX_NAME_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [NAME_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,    // target_byte
    input  logic                   s_tlast,    // is_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,    // value_byte
    output logic [2:0]             m_tuser,    // byte_valid, status[1:0]
    output logic                   m_tlast     // finished
);

    qpe_cfg_t    cfg_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    qpe_result_t step_res;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic [2:0]  m_user_reg;
    logic        m_last_reg;
    logic        s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    qpe_step #(
        .NAME_BYTES_MAX (NAME_BYTES_MAX)
    ) u_step (
        .cur     (state_reg),
        .cfg     (cfg_reg),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .nxt     (state_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.name_bytes     <= '0;
            cfg_reg.name_length    <= '0;
            cfg_reg.space_for_plus <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NAME_BYTES:     cfg_reg.name_bytes     <= cfg_wdata;
                REG_NAME_LENGTH:    cfg_reg.name_length    <= cfg_wdata[NAME_LEN_W-1:0];
                REG_SPACE_FOR_PLUS: cfg_reg.space_for_plus <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= PH_BEFORE;
            state_reg.escape_stage <= ESC_NONE;
            state_reg.high_nibble  <= '0;
            state_reg.key_position <= '0;
            state_reg.key_mismatch <= 1'b0;
            m_valid_reg            <= 1'b0;
        end else if (s_accept) begin
            state_reg   <= state_next;
            m_valid_reg <= step_res.present;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= step_res.value_byte;
            m_user_reg <= {step_res.status, step_res.byte_valid};
            m_last_reg <= step_res.finished;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[sv/qpe_step.sv]
// per-byte next-state and result logic of the query parameter extractor
// depends on qpe_pkg
module qpe_step import qpe_pkg::*; #(
    parameter int NAME_BYTES_MAX = MAX_NAME_BYTES
) (
    input  scan_state_t cur,
    input  qpe_cfg_t    cfg,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output scan_state_t nxt,
    output qpe_result_t res
);

    logic [7:0]  key_char;
    logic [7:0]  name_char;
    logic [6:0]  name_shift;
    logic [63:0] name_shifted;
    logic        do_compare;
    logic        cur_match;
    logic        empty_match;
    logic        len_ok;
    logic        fin;
    logic [1:0]  st;
    logic        plus_hit;

    assign len_ok       = cfg.name_length <= NAME_LEN_W'(NAME_BYTES_MAX);
    assign name_shift   = {cur.key_position, 3'b000};
    assign name_shifted = cfg.name_bytes >> name_shift;
    assign name_char    = name_shifted[7:0];
    assign plus_hit     = cfg.space_for_plus && (in_byte == CH_PLUS);
    assign cur_match    = !cur.key_mismatch && (cur.escape_stage == ESC_NONE) && len_ok &&
                          (NAME_LEN_W'(cur.key_position) == cfg.name_length);
    assign empty_match  = len_ok && (cfg.name_length == '0);

    always_comb begin
        nxt        = cur;
        res        = '0;
        fin        = 1'b0;
        st         = ST_FOUND;
        key_char   = plus_hit ? CH_SPACE : in_byte;
        do_compare = 1'b0;
        unique case (cur.phase)
            PH_BEFORE: begin
                if (in_byte == CH_QMARK && !in_last) begin
                    nxt.phase        = PH_KEY;
                    nxt.escape_stage = ESC_NONE;
                    nxt.high_nibble  = '0;
                    nxt.key_position = '0;
                    nxt.key_mismatch = 1'b0;
                end else if (in_last) begin
                    fin = 1'b1;
                    st  = ST_NOT_FOUND;
                end
            end
            PH_KEY: begin
                if (in_byte == CH_AMP) begin
                    if (cur_match) begin
                        fin = 1'b1;
                        st  = ST_FOUND;
                    end else begin
                        nxt.escape_stage = ESC_NONE;
                        nxt.high_nibble  = '0;
                        nxt.key_position = '0;
                        nxt.key_mismatch = 1'b0;
                        if (in_last) begin
                            fin = 1'b1;
                            st  = empty_match ? ST_FOUND : ST_NOT_FOUND;
                        end
                    end
                end else if (in_byte == CH_EQUAL) begin
                    if (cur_match) begin
                        nxt.phase        = PH_VALUE;
                        nxt.escape_stage = ESC_NONE;
                        if (in_last) begin
                            fin = 1'b1;
                            st  = ST_FOUND;
                        end
                    end else begin
                        nxt.phase = PH_SKIP;
                        if (in_last) begin
                            fin = 1'b1;
                            st  = ST_NOT_FOUND;
                        end
                    end
                end else begin
                    if (cur.escape_stage == ESC_HIGH) begin
                        if (hex_ok(in_byte)) begin
                            nxt.high_nibble  = hex_val(in_byte);
                            nxt.escape_stage = ESC_LOW;
                        end else begin
                            nxt.key_mismatch = 1'b1;
                            nxt.escape_stage = ESC_NONE;
                        end
                    end else if (cur.escape_stage == ESC_LOW) begin
                        if (hex_ok(in_byte)) begin
                            key_char   = {cur.high_nibble, hex_val(in_byte)};
                            do_compare = 1'b1;
                        end else begin
                            nxt.key_mismatch = 1'b1;
                        end
                        nxt.escape_stage = ESC_NONE;
                    end else if (in_byte == CH_PERCENT) begin
                        nxt.escape_stage = ESC_HIGH;
                    end else begin
                        do_compare = 1'b1;
                    end
                    if (do_compare) begin
                        if (NAME_LEN_W'(cur.key_position) < cfg.name_length &&
                            cur.key_position < KEY_POS_W'(NAME_BYTES_MAX) &&
                            key_char == name_char) begin
                            nxt.key_position = cur.key_position + 1'b1;
                        end else begin
                            nxt.key_mismatch = 1'b1;
                        end
                    end
                    if (in_last) begin
                        fin = 1'b1;
                        st  = (!nxt.key_mismatch && nxt.escape_stage == ESC_NONE && len_ok &&
                               NAME_LEN_W'(nxt.key_position) == cfg.name_length)
                              ? ST_FOUND : ST_NOT_FOUND;
                    end
                end
            end
            PH_VALUE: begin
                if (in_byte == CH_AMP) begin
                    fin = 1'b1;
                    st  = (cur.escape_stage != ESC_NONE) ? ST_MALFORMED : ST_FOUND;
                end else if (cur.escape_stage == ESC_HIGH) begin
                    if (hex_ok(in_byte)) begin
                        nxt.high_nibble  = hex_val(in_byte);
                        nxt.escape_stage = ESC_LOW;
                    end else begin
                        fin = 1'b1;
                        st  = ST_MALFORMED;
                    end
                end else if (cur.escape_stage == ESC_LOW) begin
                    if (hex_ok(in_byte)) begin
                        res.value_byte   = {cur.high_nibble, hex_val(in_byte)};
                        res.byte_valid   = 1'b1;
                        nxt.escape_stage = ESC_NONE;
                    end else begin
                        fin = 1'b1;
                        st  = ST_MALFORMED;
                    end
                end else if (in_byte == CH_PERCENT) begin
                    nxt.escape_stage = ESC_HIGH;
                end else begin
                    res.value_byte = key_char;
                    res.byte_valid = 1'b1;
                end
                if (in_last && !fin) begin
                    fin = 1'b1;
                    st  = (nxt.escape_stage != ESC_NONE) ? ST_MALFORMED : ST_FOUND;
                end
            end
            PH_SKIP: begin
                if (in_byte == CH_AMP) begin
                    nxt.phase        = PH_KEY;
                    nxt.escape_stage = ESC_NONE;
                    nxt.high_nibble  = '0;
                    nxt.key_position = '0;
                    nxt.key_mismatch = 1'b0;
                    if (in_last) begin
                        fin = 1'b1;
                        st  = empty_match ? ST_FOUND : ST_NOT_FOUND;
                    end
                end else if (in_last) begin
                    fin = 1'b1;
                    st  = ST_NOT_FOUND;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (fin) begin
            nxt.phase = PH_DONE;
        end
        if (in_last) begin
            nxt.phase        = PH_BEFORE;
            nxt.escape_stage = ESC_NONE;
            nxt.high_nibble  = '0;
            nxt.key_position = '0;
            nxt.key_mismatch = 1'b0;
        end

        res.finished = fin;
        res.status   = fin ? st : ST_FOUND;
        res.present  = fin || res.byte_valid;
    end

endmodule

[sv/qpe_checker.sv]
// port-level checks for query_parameter_extract_core, attached by bind
// depends on nothing but the top level's ports
module qpe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // a result without a value byte must close the target
    a_empty_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("result with neither byte nor finish");

    // status only carried on the closing transaction
    a_status_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
        else $error("status set on a non-final transaction");

    // no value data without a decoded byte
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (!m_tuser[0] || m_tuser[2:1] == 2'd2) |-> m_tdata == 8'h00 || m_tuser[0])
        else $error("value byte without byte_valid");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("undefined status code");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled transaction changed");

endmodule

bind query_parameter_extract_core qpe_checker u_qpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
